// ===== rtl/core/timer_prescaler_reload_solver_macros.svh =====
// Assertion macros for the timer prescaler and reload solver.
// Every macro samples on clk and is disabled while rst_n is low.
// No dependencies; included by the RTL files that carry assertions.
`ifndef TIMER_PRESCALER_RELOAD_SOLVER_MACROS_SVH
`define TIMER_PRESCALER_RELOAD_SOLVER_MACROS_SVH

`ifndef ASSERT_OFF

// Property that holds whenever the antecedent is true in the same cycle.
`define TPRS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tprs assertion failed");

// Property that holds in the cycle after the antecedent.
`define TPRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tprs assertion failed");

`else

`define TPRS_ASSERT_SAME(label, ante, cons)
`define TPRS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/tprs_pkg.sv =====
// Package for the timer prescaler and reload solver.
// Holds field widths, register indexes, reset values and the divider structs.
// No dependencies.
package tprs_pkg;

    localparam int FREQ_W     = 42;
    localparam int CLK_W      = 32;
    localparam int RELOAD_W   = 32;
    localparam int PRESC_W    = 16;
    localparam int DIV_W      = 42;
    localparam int CNT_W      = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [9:0] MILLI_SCALE = 10'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK_HZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RELOAD     = 2'd1;

    localparam logic [CLK_W-1:0]    TIMER_CLOCK_HZ_RST = 32'd200000000;
    localparam logic [RELOAD_W-1:0] MAX_RELOAD_RST     = 32'd65535;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== rtl/core/tprs_req_if.sv =====
// Request channel: one target frequency per transfer.
// Depends on tprs_pkg.
interface tprs_req_if import tprs_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] freq_millihz;

    modport source (output valid, output freq_millihz, input ready);
    modport sink   (input valid, input freq_millihz, output ready);

endinterface

// ===== rtl/core/tprs_rsp_if.sv =====
// Response channel: prescaler, reload and status per transfer.
// Depends on tprs_pkg.
interface tprs_rsp_if import tprs_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [PRESC_W-1:0]  prescaler;
    logic [RELOAD_W-1:0] reload;
    logic                status;

    modport source (output valid, output prescaler, output reload, output status, input ready);
    modport sink   (input valid, input prescaler, input reload, input status, output ready);

endinterface

// ===== rtl/core/tprs_div.sv =====
// Shared restoring divider: one quotient bit per cycle.
// Depends on tprs_pkg and timer_prescaler_reload_solver_macros.svh.
`include "timer_prescaler_reload_solver_macros.svh"

module tprs_div import tprs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             take;
    logic             last;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        take    = (shifted >= {1'b0, dvs_reg});
        last    = (cnt_reg == CNT_W'(DIV_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Dividend bits leave at the top of quo_reg while quotient bits enter at the bottom.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], take};
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    `TPRS_ASSERT_NEXT(a_start_busy, req.start, busy_reg)
    `TPRS_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg)

endmodule

// ===== rtl/core/timer_prescaler_reload_solver.sv =====
// Timer prescaler and reload solver. For each target frequency in millihertz the block
// forms the total count T = timer_clock_hz * 1000 / f and answers the largest reload r
// (1..max_reload) such that r + 1 divides T with quotient q = T / (r + 1) in 1..PRESCALE_SPAN,
// giving prescaler q - 1, reload r and status 0; otherwise status 1 with zero values.
// All divisions run on one shared restoring divider: T, then the smallest
// admissible quotient ceil(T / (max_reload + 1)), then one division per candidate quotient
// tried upward, at most PRESCALE_SPAN of them. A zero total count or a zero max_reload
// stops after the first division, and a zero frequency fails without a division. The next
// request is taken once the current one has moved into the output register.
// Depends on tprs_pkg, tprs_req_if, tprs_rsp_if, tprs_div and the macros header.
`include "timer_prescaler_reload_solver_macros.svh"

module timer_prescaler_reload_solver import tprs_pkg::*;
#(
    parameter longint unsigned PRESCALE_SPAN = 65536
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tprs_req_if.sink              req,
    tprs_rsp_if.source            rsp
);

    localparam int Q_W = $clog2(PRESCALE_SPAN + 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_T_LAUNCH = 8'b0000_0010,
        S_T_WAIT   = 8'b0000_0100,
        S_B_LAUNCH = 8'b0000_1000,
        S_B_WAIT   = 8'b0001_0000,
        S_Q_LAUNCH = 8'b0010_0000,
        S_Q_WAIT   = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;

    logic [CLK_W-1:0]    timer_clock_hz_reg;
    logic [RELOAD_W-1:0] max_reload_reg;

    logic [FREQ_W-1:0]   freq_reg;
    logic [DIV_W-1:0]    total_reg;
    logic [Q_W-1:0]      q_reg, q_next;
    logic [PRESC_W-1:0]  res_presc_reg, res_presc_next;
    logic [RELOAD_W-1:0] res_reload_reg, res_reload_next;
    logic                res_status_reg, res_status_next;

    logic                rsp_valid_reg;
    logic [PRESC_W-1:0]  rsp_presc_reg;
    logic [RELOAD_W-1:0] rsp_reload_reg;
    logic                rsp_status_reg;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic [DIV_W-1:0]    numerator;
    logic [RELOAD_W:0]   max_div;
    logic [DIV_W:0]      q_start;
    logic [Q_W-1:0]      q_minus1;
    logic [DIV_W-1:0]    reload_calc;
    logic                accept;
    logic                emit_load;

    tprs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign emit_load = (state_reg == S_EMIT) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        numerator   = DIV_W'(timer_clock_hz_reg) * DIV_W'(MILLI_SCALE);
        max_div     = (RELOAD_W + 1)'(max_reload_reg) + (RELOAD_W + 1)'(1);
        q_start     = (DIV_W + 1)'(div_rsp.quotient)
                      + (DIV_W + 1)'(div_rsp.remainder != '0);
        q_minus1    = q_reg - Q_W'(1);
        reload_calc = div_rsp.quotient - DIV_W'(1);
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = total_reg;
        div_req.divisor  = DIV_W'(q_reg);
        case (state_reg)
            S_T_LAUNCH:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = numerator;
                div_req.divisor  = freq_reg;
            end
            S_B_LAUNCH:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = DIV_W'(max_div);
            end
            S_Q_LAUNCH:
            begin
                div_req.start = 1'b1;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        q_next          = q_reg;
        res_presc_next  = res_presc_reg;
        res_reload_next = res_reload_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_presc_next  = '0;
                    res_reload_next = '0;
                    res_status_next = 1'b1;
                    // Zero frequency fails at once.
                    state_next = (req.freq_millihz == '0) ? S_EMIT : S_T_LAUNCH;
                end
            end
            S_T_LAUNCH:
            begin
                state_next = S_T_WAIT;
            end
            S_T_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient == '0 || max_reload_reg == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_B_LAUNCH;
                    end
                end
            end
            S_B_LAUNCH:
            begin
                state_next = S_B_WAIT;
            end
            S_B_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // Start at ceil(T / (max_reload + 1)) so every candidate quotient gives a reload within max_reload.
                    if (q_start > (DIV_W + 1)'(PRESCALE_SPAN))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        q_next     = Q_W'(q_start);
                        state_next = S_Q_LAUNCH;
                    end
                end
            end
            S_Q_LAUNCH:
            begin
                state_next = S_Q_WAIT;
            end
            S_Q_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient < DIV_W'(2))
                    begin
                        state_next = S_EMIT;
                    end
                    else if (div_rsp.remainder == '0)
                    begin
                        res_presc_next  = PRESC_W'(q_minus1);
                        res_reload_next = reload_calc[RELOAD_W-1:0];
                        res_status_next = 1'b0;
                        state_next      = S_EMIT;
                    end
                    else if (q_reg == Q_W'(PRESCALE_SPAN))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        q_next     = q_reg + Q_W'(1);
                        state_next = S_Q_LAUNCH;
                    end
                end
            end
            S_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            timer_clock_hz_reg <= TIMER_CLOCK_HZ_RST;
            max_reload_reg     <= MAX_RELOAD_RST;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TIMER_CLOCK_HZ: timer_clock_hz_reg <= cfg_data[CLK_W-1:0];
                    REG_MAX_RELOAD:     max_reload_reg     <= cfg_data[RELOAD_W-1:0];
                    default:            ;
                endcase
            end
            if (emit_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            freq_reg <= req.freq_millihz;
        end
        if (state_reg == S_T_WAIT && div_rsp.done)
        begin
            total_reg <= div_rsp.quotient;
        end
        q_reg          <= q_next;
        res_presc_reg  <= res_presc_next;
        res_reload_reg <= res_reload_next;
        res_status_reg <= res_status_next;
        if (emit_load)
        begin
            rsp_presc_reg  <= res_presc_reg;
            rsp_reload_reg <= res_reload_reg;
            rsp_status_reg <= res_status_reg;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.prescaler = rsp_presc_reg;
    assign rsp.reload    = rsp_reload_reg;
    assign rsp.status    = rsp_status_reg;

    `TPRS_ASSERT_SAME(a_start_idle_div, div_req.start, !div_rsp.busy)
    `TPRS_ASSERT_SAME(a_fit_nonzero, rsp.valid && !rsp.status, rsp.reload != '0)
    `TPRS_ASSERT_SAME(a_fail_zero, rsp.valid && rsp.status,
                      rsp.prescaler == '0 && rsp.reload == '0)
    `TPRS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != S_IDLE)

endmodule

// ===== bench/tb_timer_prescaler_reload_solver.sv =====
`timescale 1ns / 1ps
// Self-checking bench for timer_prescaler_reload_solver: directed table, then random phases.
// Depends on tprs_pkg, tprs_req_if, tprs_rsp_if and the solver RTL.
module tb_timer_prescaler_reload_solver;
    import tprs_pkg::*;

    localparam longint unsigned SPAN = 65536;
    localparam int unsigned DIV_CYCLES = 44;
    localparam int unsigned HOLD_CYCLES = 20000;
    localparam int unsigned WATCHDOG_CYCLES =
        3 * (DIV_CYCLES * (3 + 65536) + HOLD_CYCLES + 12);
    localparam longint unsigned RAND_TRY_CAP = 120;
    localparam int RAND_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 16;
    localparam int PLAN_ROWS = 31;

    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic STATUS_FIT = 1'b0;
    localparam logic STATUS_NO_FIT = 1'b1;

    typedef struct packed {
        logic [PRESC_W-1:0]  prescaler;
        logic [RELOAD_W-1:0] reload;
        logic                status;
    } timer_setting_t;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic [FREQ_W-1:0]     freq;
        logic                  fixed;
        timer_setting_t        setting;
    } plan_row_t;

    localparam timer_setting_t NO_FIT = '{prescaler: '0, reload: '0, status: STATUS_NO_FIT};
    localparam timer_setting_t NO_SETTING = '0;

    // Rows marked fixed carry their answer; the rest go through solve_setting.
    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd0, 1'b1, NO_FIT},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, FREQ_MAX, 1'b1, NO_FIT},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd1000, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd100000000000, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd46, 1'b0, NO_SETTING},
        '{ROW_CFG, REG_SPARE_2, 32'hFFFF_FFFF, '0, 1'b0, NO_SETTING},
        '{ROW_CFG, REG_SPARE_3, 32'd0, '0, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd500, 1'b0, NO_SETTING},
        '{ROW_CFG, REG_TIMER_CLOCK_HZ, 32'd4294901760, '0, 1'b0, NO_SETTING},
        '{ROW_CFG, REG_MAX_RELOAD, 32'd65534, '0, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd1000, 1'b0, NO_SETTING},
        '{ROW_CFG, REG_TIMER_CLOCK_HZ, 32'hFFFF_FFFF, '0, 1'b0, NO_SETTING},
        '{ROW_CFG, REG_MAX_RELOAD, 32'hFFFF_FFFF, '0, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd1, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, FREQ_MAX, 1'b1, NO_FIT},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd1000, 1'b0, NO_SETTING},
        '{ROW_CFG, REG_TIMER_CLOCK_HZ, 32'd536870912, '0, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd1, 1'b0, NO_SETTING},
        '{ROW_CFG, REG_TIMER_CLOCK_HZ, 32'd200000000, '0, 1'b0, NO_SETTING},
        '{ROW_CFG, REG_MAX_RELOAD, 32'd1, '0, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd50000000000, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd1525878, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd1000, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd1525855, 1'b0, NO_SETTING},
        '{ROW_CFG, REG_MAX_RELOAD, 32'd0, '0, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd1000, 1'b1, NO_FIT},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd0, 1'b1, NO_FIT},
        '{ROW_CFG, REG_TIMER_CLOCK_HZ, 32'd0, '0, 1'b0, NO_SETTING},
        '{ROW_CFG, REG_MAX_RELOAD, 32'd65535, '0, 1'b0, NO_SETTING},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, 42'd1, 1'b1, NO_FIT},
        '{ROW_ITEM, REG_TIMER_CLOCK_HZ, '0, FREQ_MAX, 1'b1, NO_FIT}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tprs_req_if req_ch ();
    tprs_rsp_if rsp_ch ();

    timer_prescaler_reload_solver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    logic [CLK_W-1:0]    solver_clock_hz;
    logic [RELOAD_W-1:0] solver_max_reload;
    timer_setting_t      settings_due [$];

    bit          gaps_on;
    bit          pressure_req;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned fits_seen;
    int unsigned writes_done;
    int unsigned fail_count;
    int unsigned quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Smallest quotient q >= ceil(T / (max_reload + 1)) that divides T with T / q >= 2
    // gives the largest reload. tries counts the quotients walked, the block's cost.
    function automatic timer_setting_t solve_setting(input logic [FREQ_W-1:0] freq,
                                                     input longint unsigned try_cap,
                                                     output longint unsigned tries);
        longint unsigned total;
        longint unsigned dmax;
        longint unsigned q;
        timer_setting_t  s;
        s = NO_FIT;
        tries = 0;
        if (freq != '0)
        begin
            total = solver_clock_hz;
            total = (total * 1000) / freq;
            dmax = solver_max_reload;
            dmax = dmax + 1;
            if (total != 0 && dmax >= 2)
            begin
                q = (total + dmax - 1) / dmax;
                if (q == 0)
                    q = 1;
                while (q <= SPAN && tries <= try_cap && s.status == STATUS_NO_FIT)
                begin
                    tries++;
                    if (total % q == 0 && total / q >= 2)
                    begin
                        s.prescaler = PRESC_W'(q - 1);
                        s.reload = RELOAD_W'(total / q - 1);
                        s.status = STATUS_FIT;
                    end
                    q++;
                end
            end
        end
        return s;
    endfunction

    function automatic logic [CLK_W-1:0] pick_clock();
        case ($urandom_range(0, 4))
            0: return 32'd200000000;
            1: return '1;
            2: return $urandom_range(1000, 1000000);
            3: return 32'd168000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RELOAD_W-1:0] pick_max_reload();
        case ($urandom_range(0, 4))
            0: return 32'd65535;
            1: return '1;
            2: return 32'd1;
            3: return $urandom_range(2, 1023);
            default: return $urandom;
        endcase
    endfunction

    // Mostly back a frequency out of a chosen quotient and divisor; keep the search short.
    task automatic pick_random_freq(output logic [FREQ_W-1:0] freq,
                                    output timer_setting_t want);
        longint unsigned c_total;
        longint unsigned dmax;
        longint unsigned q;
        longint unsigned d;
        longint unsigned t;
        longint unsigned tries;
        logic [FREQ_W-1:0] f;
        timer_setting_t    s;
        bit                ok;
        c_total = solver_clock_hz;
        c_total = c_total * 1000;
        dmax = solver_max_reload;
        dmax = dmax + 1;
        ok = 1'b0;
        f = '0;
        s = NO_FIT;
        for (int n = 0; n < 40 && !ok; n++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                q = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                : $urandom_range(1, 65536);
                if (dmax < 2)
                    d = 2;
                else if ($urandom_range(0, 2) != 0)
                    d = dmax - ((dmax >= 10) ? $urandom_range(0, 7) : 0);
                else
                    d = 2 + ({$urandom, $urandom} % (dmax - 1));
                t = q * d;
                if (t != 0 && t <= c_total)
                    f = FREQ_W'(c_total / t);
                else
                    f = FREQ_W'({$urandom, $urandom});
            end
            else
            begin
                f = FREQ_W'({$urandom, $urandom});
                f = f >> $urandom_range(0, FREQ_W - 1);
            end
            s = solve_setting(f, RAND_TRY_CAP, tries);
            ok = (tries <= RAND_TRY_CAP);
        end
        if (!ok)
        begin
            // above clock * 1000: total count is zero
            f = FREQ_W'(c_total + 1);
            s = solve_setting(f, SPAN, tries);
        end
        freq = f;
        want = s;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic offer_freq(input logic [FREQ_W-1:0] freq, input timer_setting_t want);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.freq_millihz <= freq;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        settings_due.push_back(want);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (settings_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (index == REG_TIMER_CLOCK_HZ)
            solver_clock_hz = value;
        else if (index == REG_MAX_RELOAD)
            solver_max_reload = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        writes_done++;
    endtask

    initial
    begin : stimulus
        logic [FREQ_W-1:0] freq;
        timer_setting_t    want;
        longint unsigned   tries;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TIMER_CLOCK_HZ;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.freq_millihz = '0;
        rsp_ch.ready = 1'b0;
        solver_clock_hz = TIMER_CLOCK_HZ_RST;
        solver_max_reload = MAX_RELOAD_RST;
        gaps_on = 1'b1;
        pressure_req = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(plan[i].index, plan[i].value);
            end
            else
            begin
                if (plan[i].fixed)
                    want = plan[i].setting;
                else
                    want = solve_setting(plan[i].freq, SPAN, tries);
                offer_freq(plan[i].freq, want);
            end
        end
        drain();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            // last phase runs back to back on both sides
            gaps_on = (p != RAND_PHASES - 1);
            write_reg(REG_TIMER_CLOCK_HZ, (p == 0) ? TIMER_CLOCK_HZ_RST : pick_clock());
            write_reg(REG_MAX_RELOAD, (p == 0) ? MAX_RELOAD_RST : pick_max_reload());
            if (p == 1)
                pressure_req = 1'b1;
            repeat (ITEMS_PER_PHASE)
            begin
                pick_random_freq(freq, want);
                offer_freq(freq, want);
            end
            drain();
        end

        repeat (200) @(negedge clk);
        $display("covered %0d frequencies and %0d register writes over %0d setups;",
                 items_sent, writes_done, RAND_PHASES + 1);
        $display("%0d settings checked, %0d exact fits, %0d failures, %0d still expected",
                 results_seen, fits_seen, fail_count, settings_due.size());
        if (fail_count == 0 && settings_due.size() == 0)
            $display("tb_timer_prescaler_reload_solver: clean");
        else
            $display("tb_timer_prescaler_reload_solver: errors");
        $finish;
    end

    // Response side: random short stalls, one long hold-off on request.
    initial
    begin : sink_side
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (pressure_req)
            begin
                pressure_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            else if (hold_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 12);
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        timer_setting_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (settings_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] unexpected transfer: prescaler %0d reload %0d status %0b",
                             $realtime, rsp_ch.prescaler, rsp_ch.reload, rsp_ch.status);
            end
            else
            begin
                want = settings_due.pop_front();
                if (rsp_ch.prescaler !== want.prescaler || rsp_ch.reload !== want.reload
                    || rsp_ch.status !== want.status)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 $realtime, want.prescaler, want.reload, want.status,
                                 rsp_ch.prescaler, rsp_ch.reload, rsp_ch.status);
                end
                if (want.status == STATUS_FIT)
                    fits_seen++;
            end
        end
    end

    // Drop out if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_CYCLES - 1)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
            $display("tb_timer_prescaler_reload_solver: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tprs_pkg.sv
rtl/core/tprs_req_if.sv
rtl/core/tprs_rsp_if.sv
rtl/core/tprs_div.sv
rtl/core/timer_prescaler_reload_solver.sv
bench/tb_timer_prescaler_reload_solver.sv
